/* rtl/core/qdct_pkg.sv */
// ---------------------------------------------------------------------------
// qdct_pkg
// Shared constants for the quad diagonal crossing test.
// ---------------------------------------------------------------------------
package qdct_pkg;

   // default coordinate width: signed Q12.4
   localparam int COORD_BITS_DEF = 16;
   localparam int COORD_BITS_MIN = 8;
   localparam int COORD_BITS_MAX = 24;

endpackage

/* rtl/core/quad_diagonal_crossing_test.sv */
// Throughput: one transaction per cycle while rsp_ready lets results drain;
// the stages are the difference, multiplier, determinant/numerator and
// compare registers, and rsp_valid comes from the last of them.
// Each stage holds its item under back-pressure and fills any bubble ahead.
// Reset (synchronous, active high) clears every stage valid; no item in
// flight survives it.
// ---------------------------------------------------------------------------
// quad_diagonal_crossing_test
// Decides whether the diagonals 0-2 and 1-3 of a quad cross within both
// segments (convex quad), using exact integer compares against the
// determinant. A zero determinant flags parallel diagonals.
// ---------------------------------------------------------------------------
module quad_diagonal_crossing_test #(
   parameter int COORD_BITS = qdct_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_corner0_x,
   input  logic signed [COORD_BITS-1:0] req_corner0_y,
   input  logic signed [COORD_BITS-1:0] req_corner1_x,
   input  logic signed [COORD_BITS-1:0] req_corner1_y,
   input  logic signed [COORD_BITS-1:0] req_corner2_x,
   input  logic signed [COORD_BITS-1:0] req_corner2_y,
   input  logic signed [COORD_BITS-1:0] req_corner3_x,
   input  logic signed [COORD_BITS-1:0] req_corner3_y,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_convex,
   output logic                         rsp_parallel_diagonals
);
   import qdct_pkg::*;

   localparam int D = COORD_BITS + 1;   // coordinate difference
   localparam int P = 2 * D;            // product of two differences
   localparam int N = P + 1;            // difference of two products

   // stage enables: a stage loads when empty or when it hands on
   logic en1, en2, en3, en4;

   // stage 1: coordinate differences
   logic                s1_valid_ff, s1_valid_in;
   logic signed [D-1:0] s1_abx_ff, s1_aby_ff, s1_cex_ff, s1_cey_ff, s1_acx_ff, s1_acy_ff;
   logic signed [D-1:0] s1_abx_in, s1_aby_in, s1_cex_in, s1_cey_in, s1_acx_in, s1_acy_in;

   // stage 2: products
   logic                s2_valid_ff, s2_valid_in;
   logic signed [P-1:0] s2_p_ff [6];
   logic signed [P-1:0] s2_p_in [6];

   // stage 3: determinant and numerators
   logic                s3_valid_ff, s3_valid_in;
   logic signed [N-1:0] s3_det_ff, s3_tnum_ff, s3_unum_ff;
   logic signed [N-1:0] s3_det_in, s3_tnum_in, s3_unum_in;

   // stage 4: result register
   logic s4_valid_ff, s4_valid_in;
   logic s4_convex_ff, s4_convex_in;
   logic s4_par_ff, s4_par_in;

   logic det_zero, det_pos, t_in_span, u_in_span;

   assign en4       = !s4_valid_ff || rsp_ready;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;

   // stage 1
   always_comb begin
      s1_valid_in = en1 ? req_valid : s1_valid_ff;
      s1_abx_in   = D'(req_corner0_x) - D'(req_corner2_x);
      s1_aby_in   = D'(req_corner0_y) - D'(req_corner2_y);
      s1_cex_in   = D'(req_corner1_x) - D'(req_corner3_x);
      s1_cey_in   = D'(req_corner1_y) - D'(req_corner3_y);
      s1_acx_in   = D'(req_corner0_x) - D'(req_corner1_x);
      s1_acy_in   = D'(req_corner0_y) - D'(req_corner1_y);
   end

   // stage 2
   always_comb begin
      s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;
      s2_p_in[0]  = P'(s1_abx_ff) * P'(s1_cey_ff);
      s2_p_in[1]  = P'(s1_aby_ff) * P'(s1_cex_ff);
      s2_p_in[2]  = P'(s1_acx_ff) * P'(s1_cey_ff);
      s2_p_in[3]  = P'(s1_acy_ff) * P'(s1_cex_ff);
      s2_p_in[4]  = P'(s1_aby_ff) * P'(s1_acx_ff);
      s2_p_in[5]  = P'(s1_abx_ff) * P'(s1_acy_ff);
   end

   // stage 3
   always_comb begin
      s3_valid_in = en3 ? s2_valid_ff : s3_valid_ff;
      s3_det_in   = N'(s2_p_ff[0]) - N'(s2_p_ff[1]);
      s3_tnum_in  = N'(s2_p_ff[2]) - N'(s2_p_ff[3]);
      s3_unum_in  = N'(s2_p_ff[4]) - N'(s2_p_ff[5]);
   end

   // stage 4: 0 <= num/det <= 1, with the determinant's sign folded in
   always_comb begin
      det_zero  = (s3_det_ff == '0);
      det_pos   = !s3_det_ff[N-1] && !det_zero;
      t_in_span = det_pos
                ? (!s3_tnum_ff[N-1] && (s3_tnum_ff <= s3_det_ff))
                : ((s3_tnum_ff[N-1] || (s3_tnum_ff == '0)) && (s3_tnum_ff >= s3_det_ff));
      u_in_span = det_pos
                ? (!s3_unum_ff[N-1] && (s3_unum_ff <= s3_det_ff))
                : ((s3_unum_ff[N-1] || (s3_unum_ff == '0)) && (s3_unum_ff >= s3_det_ff));
      s4_valid_in  = en4 ? s3_valid_ff : s4_valid_ff;
      s4_par_in    = det_zero;
      s4_convex_in = !det_zero && t_in_span && u_in_span;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_abx_ff <= s1_abx_in;
         s1_aby_ff <= s1_aby_in;
         s1_cex_ff <= s1_cex_in;
         s1_cey_ff <= s1_cey_in;
         s1_acx_ff <= s1_acx_in;
         s1_acy_ff <= s1_acy_in;
      end
      if (en2) begin
         s2_p_ff <= s2_p_in;
      end
      if (en3) begin
         s3_det_ff  <= s3_det_in;
         s3_tnum_ff <= s3_tnum_in;
         s3_unum_ff <= s3_unum_in;
      end
      if (en4) begin
         s4_convex_ff <= s4_convex_in;
         s4_par_ff    <= s4_par_in;
      end
   end

   assign rsp_valid              = s4_valid_ff;
   assign rsp_convex             = s4_convex_ff;
   assign rsp_parallel_diagonals = s4_par_ff;

endmodule

/* rtl/core/qdct_checker.sv */
// ---------------------------------------------------------------------------
// qdct_checker
// Port-level checks for quad_diagonal_crossing_test, bound to the top level.
// ---------------------------------------------------------------------------
module qdct_checker #(
   parameter int COORD_BITS = qdct_pkg::COORD_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic signed [COORD_BITS-1:0] req_corner0_x,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_convex,
   input logic                         rsp_parallel_diagonals
);
   import qdct_pkg::*;

   // nothing survives reset
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high straight after reset");

   // a parallel result can never be convex
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_convex && rsp_parallel_diagonals))
      else $error("convex and parallel flags both set");

   // the pipe takes a transaction whenever the output side can drain
   a_no_needless_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low while output can drain");

   // a stalled result holds
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_convex) && $stable(rsp_parallel_diagonals)))
      else $error("stalled result changed");

   // an offered transaction waits, with its corner 0 x coordinate unchanged
   a_req_holds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_corner0_x)))
      else $error("offered transaction dropped or changed");

endmodule

bind quad_diagonal_crossing_test qdct_checker #(
   .COORD_BITS (COORD_BITS)
) u_qdct_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_ready              (req_ready),
   .req_corner0_x          (req_corner0_x),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_convex             (rsp_convex),
   .rsp_parallel_diagonals (rsp_parallel_diagonals)
);

/* verif/quad_diagonal_crossing_test_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// quad_diagonal_crossing_test_tb
// Streams candidate quads through the diagonal crossing test with random
// gaps on both channels and two long response hold-offs. Each accepted
// transaction is scored against an exact integer predictor, in order.
// ---------------------------------------------------------------------------
module quad_diagonal_crossing_test_tb;

   localparam int CB = qdct_pkg::COORD_BITS_DEF;
   localparam int N_RANDOM = 1400;

   typedef logic [CB-1:0] coord_type;

   typedef struct packed {
      coord_type x0, y0, x1, y1, x2, y2, x3, y3;
   } quad_type;

   typedef struct packed {
      logic convex;
      logic parallel_diagonals;
   } crossing_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_corner0_x = '0, req_corner0_y = '0;
   coord_type req_corner1_x = '0, req_corner1_y = '0;
   coord_type req_corner2_x = '0, req_corner2_y = '0;
   coord_type req_corner3_x = '0, req_corner3_y = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_convex;
   logic      rsp_parallel_diagonals;

   quad_type     quad_backlog[$];
   crossing_type crossing_due[$];
   quad_type     quad_on_bus;
   int           req_gap = 0;
   int           rsp_stall = 0;
   bit           req_calm = 0;
   bit           rsp_calm = 0;
   int           mismatch_count = 0;

   // response hold-off
   logic      hold_active = 1'b0;
   int        hold_left = 0;
   int        hold_done = 0;
   int        req_seen = 0;

   quad_diagonal_crossing_test #(.COORD_BITS(CB)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_corner0_x(req_corner0_x),
      .req_corner0_y(req_corner0_y),
      .req_corner1_x(req_corner1_x),
      .req_corner1_y(req_corner1_y),
      .req_corner2_x(req_corner2_x),
      .req_corner2_y(req_corner2_y),
      .req_corner3_x(req_corner3_x),
      .req_corner3_y(req_corner3_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_convex(rsp_convex),
      .rsp_parallel_diagonals(rsp_parallel_diagonals)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10ms;
      $display("Mismatches found");
      $finish;
   end

   // 0 <= num/den <= 1, den nonzero
   function automatic bit in_unit(longint num, longint den);
      if (den > 0)
         return num >= 0 && num <= den;
      return num <= 0 && num >= den;
   endfunction

   function automatic crossing_type predict_crossing(quad_type q);
      longint ax, ay, bx, by, cx, cy, ex, ey;
      longint abx, aby, cex, cey, acx, acy, det, tnum, unum;
      crossing_type r;
      ax = longint'($signed(q.x0));
      ay = longint'($signed(q.y0));
      cx = longint'($signed(q.x1));
      cy = longint'($signed(q.y1));
      bx = longint'($signed(q.x2));
      by = longint'($signed(q.y2));
      ex = longint'($signed(q.x3));
      ey = longint'($signed(q.y3));
      abx = ax - bx;
      aby = ay - by;
      cex = cx - ex;
      cey = cy - ey;
      acx = ax - cx;
      acy = ay - cy;
      det = abx * cey - aby * cex;
      tnum = acx * cey - acy * cex;
      unum = aby * acx - abx * acy;
      r.parallel_diagonals = (det == 0);
      r.convex = (det != 0) && in_unit(tnum, det) && in_unit(unum, det);
      return r;
   endfunction

   // mostly short gaps, a few long, with occasional stretches of none
   function automatic int pick_gap(inout bit calm);
      int r;
      if ($urandom_range(0, 149) == 0)
         calm = !calm;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int rand_coord(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(0, 7))
         0: return CB'(-32768);
         1: return CB'(-32767);
         2: return CB'(-1);
         3: return CB'(0);
         4: return CB'(1);
         5: return CB'(32766);
         6: return CB'(32767);
         default: return CB'($urandom());
      endcase
   endfunction

   task automatic add_quad(int x0, int y0, int x1, int y1, int x2, int y2, int x3, int y3);
      quad_type q;
      q.x0 = CB'(x0); q.y0 = CB'(y0);
      q.x1 = CB'(x1); q.y1 = CB'(y1);
      q.x2 = CB'(x2); q.y2 = CB'(y2);
      q.x3 = CB'(x3); q.y3 = CB'(y3);
      quad_backlog.push_back(q);
   endtask

   task automatic add_random_quad();
      int x0, y0, x1, y1, x2, y2, x3, y3, mx, my, vx, vy, dx, dy, k, m, s;
      quad_type q;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         // second diagonal pivots about the first one's midpoint
         x0 = $signed(rand_coord(-4000, 4000)); y0 = $signed(rand_coord(-4000, 4000));
         x2 = $signed(rand_coord(-4000, 4000)); y2 = $signed(rand_coord(-4000, 4000));
         mx = (x0 + x2) / 2; my = (y0 + y2) / 2;
         vx = $signed(rand_coord(-3000, 3000)); vy = $signed(rand_coord(-3000, 3000));
         s = $urandom_range(1, 3);
         add_quad(x0, y0, mx + vx, my + vy, x2, y2, mx - s * vx, my - s * vy);
      end else if (pick < 50) begin
         q = {$urandom(), $urandom(), $urandom(), $urandom()};
         quad_backlog.push_back(q);
      end else if (pick < 65) begin
         add_quad($signed(rand_coord(-32, 32)), $signed(rand_coord(-32, 32)),
                  $signed(rand_coord(-32, 32)), $signed(rand_coord(-32, 32)),
                  $signed(rand_coord(-32, 32)), $signed(rand_coord(-32, 32)),
                  $signed(rand_coord(-32, 32)), $signed(rand_coord(-32, 32)));
      end else if (pick < 80) begin
         // both diagonals along one direction
         dx = $signed(rand_coord(-200, 200)); dy = $signed(rand_coord(-200, 200));
         k = $signed(rand_coord(-3, 3)); m = $signed(rand_coord(-3, 3));
         x0 = $signed(rand_coord(-8000, 8000)); y0 = $signed(rand_coord(-8000, 8000));
         x1 = $signed(rand_coord(-8000, 8000)); y1 = $signed(rand_coord(-8000, 8000));
         add_quad(x0, y0, x1, y1, x0 + k * dx, y0 + k * dy, x1 + m * dx, y1 + m * dy);
      end else if (pick < 90) begin
         // corner 2 sits exactly at the middle of the second diagonal
         x1 = $signed(rand_coord(-8000, 8000)); y1 = $signed(rand_coord(-8000, 8000));
         vx = $signed(rand_coord(-2000, 2000)); vy = $signed(rand_coord(-2000, 2000));
         add_quad($signed(rand_coord(-8000, 8000)), $signed(rand_coord(-8000, 8000)),
                  x1, y1, x1 + vx, y1 + vy, x1 + 2 * vx, y1 + 2 * vy);
      end else begin
         q.x0 = extreme_coord(); q.y0 = extreme_coord();
         q.x1 = extreme_coord(); q.y1 = extreme_coord();
         q.x2 = extreme_coord(); q.y2 = extreme_coord();
         q.x3 = extreme_coord(); q.y3 = extreme_coord();
         quad_backlog.push_back(q);
      end
   endtask

   // stimulus and end of run
   initial begin
      add_quad(0, 0, 0, 0, 0, 0, 0, 0);
      add_quad(0, 0, 160, 0, 160, 160, 0, 160);
      add_quad(0, 160, 160, 160, 160, 0, 0, 0);
      add_quad(0, 0, 160, 160, 160, 0, 0, 160);
      add_quad(0, 0, 100, 0, 10, 10, 0, 100);
      add_quad(0, 0, 100, 0, 50, 50, 0, 100);
      add_quad(50, 50, 100, 0, 0, 0, 0, 100);
      add_quad(0, 0, 100, 0, 49, 49, 0, 100);
      add_quad(0, 0, 100, 0, 51, 51, 0, 100);
      add_quad(0, 0, 100, 0, 50, 50, 50, 50);
      add_quad(0, 0, 10, 0, 20, 0, 30, 0);
      add_quad(5, 5, 1, 2, 5, 5, 9, 9);
      add_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
      add_quad(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768);
      add_quad(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768);
      add_quad(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
      add_quad(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
      add_quad(-32768, -32768, 32767, -32767, 32767, 32767, -32767, 32767);
      add_quad(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845);
      add_quad(-1, -1, 1, -1, 1, 1, -1, 1);
      add_quad(32767, 0, 0, 32767, -32768, 0, 0, -32768);
      add_quad(-32768, 0, 32767, 0, 32767, 0, -32768, 0);
      for (int i = 0; i < N_RANDOM; i++)
         add_random_quad();

      // sample between edges so the driver's updates have settled
      do
         @(negedge clock);
      while (quad_backlog.size() != 0 || req_valid || crossing_due.size() != 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && crossing_due.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold the offered transaction
      end else begin
         if (req_valid)
            crossing_due.push_back(predict_crossing(quad_on_bus));
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (quad_backlog.size() != 0) begin
            quad_on_bus = quad_backlog.pop_front();
            req_corner0_x <= quad_on_bus.x0;
            req_corner0_y <= quad_on_bus.y0;
            req_corner1_x <= quad_on_bus.x1;
            req_corner1_y <= quad_on_bus.y1;
            req_corner2_x <= quad_on_bus.x2;
            req_corner2_y <= quad_on_bus.y2;
            req_corner3_x <= quad_on_bus.x3;
            req_corner3_y <= quad_on_bus.y3;
            req_valid <= 1'b1;
            req_gap = pick_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long response hold-off, twice, while the sender keeps offering
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            req_seen <= req_seen + 1;
         if (hold_active) begin
            if (hold_left <= 1) begin
               hold_active <= 1'b0;
               hold_done <= hold_done + 1;
            end
            hold_left <= hold_left - 1;
         end else if ((hold_done == 0 && req_seen >= 200) ||
                      (hold_done == 1 && req_seen >= 800)) begin
            hold_active <= 1'b1;
            hold_left <= 300;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      crossing_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (crossing_due.size() == 0) begin
               $display("%0t: result with no transaction outstanding (convex %0b parallel %0b)",
                        $time, rsp_convex, rsp_parallel_diagonals);
               mismatch_count++;
            end else begin
               due = crossing_due.pop_front();
               if (rsp_convex !== due.convex) begin
                  $display("%0t: convex expected %0b actual %0b",
                           $time, due.convex, rsp_convex);
                  mismatch_count++;
               end
               if (rsp_parallel_diagonals !== due.parallel_diagonals) begin
                  $display("%0t: parallel_diagonals expected %0b actual %0b",
                           $time, due.parallel_diagonals, rsp_parallel_diagonals);
                  mismatch_count++;
               end
            end
            rsp_stall = pick_gap(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (hold_active) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

endmodule
